// ===== design/mwo_pkg.sv =====
package mwo_pkg;

  // Quarter-wave table resolution; must be a power of two.
  localparam int unsigned SINE_TABLE_DEPTH = 256;
  // Width of the run counter.
  localparam int unsigned COUNT_WIDTH = 24;

  localparam int unsigned SINE_IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned ROM_ADDR_W  = SINE_IDX_W + 1;
  localparam int unsigned PHASE_SHIFT = SINE_IDX_W + 2;
  localparam int unsigned ROM_W       = 17;

  // Register indexes; register i sits at byte address 4*i.
  localparam logic [2:0] REG_WAVEFORM = 3'd0;
  localparam logic [2:0] REG_PERIOD   = 3'd1;
  localparam logic [2:0] REG_PULSE_ON = 3'd2;
  localparam logic [2:0] REG_AMP      = 3'd3;
  localparam logic [2:0] REG_TOTAL    = 3'd4;

  // Waveform select codes.
  localparam logic [1:0] WAVE_SINE  = 2'd0;
  localparam logic [1:0] WAVE_SAW   = 2'd1;
  localparam logic [1:0] WAVE_TRI   = 2'd2;
  localparam logic [1:0] WAVE_PULSE = 2'd3;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TaylorDiv [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef logic [ROM_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // sin(pi/2 * k / D) in Q16, evaluated with an eight-term Taylor series in Q30.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x  = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = x;
      s  = x;
      for (int n = 1; n <= 7; n++) begin
        t = ((t * x2) >> 30) / 64'(TaylorDiv[n]);
        if ((n & 1) != 0) begin
          s = (s >= t) ? (s - t) : 64'd0;
        end else begin
          s = s + t;
        end
      end
      e = (s + 64'd8192) >> 14;
      rom[k] = (e > 64'd65536) ? 17'd65536 : e[ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== design/multi_waveform_oscillator_unit.sv =====
// Unipolar waveform generator: sine (raised), sawtooth, triangle and pulse.
// Input channel (in_valid_i / in_stall_o, payload restart_i): every transfer
// is one sample tick and yields exactly one result on the output channel
// (out_valid_o / out_stall_i, payload sample_o and last_o).
// Registers are written over the APB port (waveform, period_len, pulse_on_len,
// amplitude, total_len at byte addresses 0, 4, 8, 12, 16); pready is always high.
// Timing: an item is taken only while the sequencer is idle; the sequencer
// holds one item from acceptance until its result moves to the output register.
// Sawtooth, triangle and sine run through the 16-step restoring divider, which
// they share; sine adds the table read, multiply and rounding steps, and pulse
// skips the divider.
// The result sits in an output register, so the block takes the next tick while
// a result still waits. When the receiver stalls, a finished result waits in
// the sequencer until the output register is free, and the input stalls.
// Reset clears phase and run count, loads the register defaults and empties
// the output register.
module multi_waveform_oscillator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] sample_o,
  output logic        last_o
);

  localparam int unsigned CW   = mwo_pkg::COUNT_WIDTH;
  localparam int unsigned TL_W = 24;
  localparam int unsigned LW   = ((CW > TL_W) ? CW : TL_W) + 1;
  localparam logic [CW-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_SROM, ST_SMUL, ST_SRND, ST_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [1:0]      wave_q, wave_d;
  logic [15:0]     period_q, period_d;
  logic [15:0]     pulse_on_q, pulse_on_d;
  logic [15:0]     amp_q, amp_d;
  logic [TL_W-1:0] total_q, total_d;

  logic [15:0]   phase_q, phase_d;
  logic [CW-1:0] run_q, run_d;

  logic [15:0] i_q, i_d;
  logic        last_q, last_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] den_q, den_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [17:0] v_q, v_d;
  logic [33:0] prod_q, prod_d;
  logic [15:0] res_q, res_d;

  logic        out_valid_q, out_valid_d;
  logic [15:0] sample_q, sample_d;
  logic        out_last_q, out_last_d;

  logic            cfg_write;
  logic            in_accept;
  logic            out_accept;
  logic [15:0]     n_eff;
  logic [TL_W-1:0] tl_eff;
  logic [CW-1:0]   rc_start;
  logic [15:0]     ph_start;
  logic [15:0]     ph_cur;
  logic [LW-1:0]   rc_inc;
  logic [16:0]     ph_inc;
  logic            is_last;

  logic [15:0] tri_half;
  logic [15:0] tri_arg;
  logic [17:0] mul_b;
  logic [33:0] mul_p;
  logic [31:0] div_num;

  logic [16:0] trial;
  logic        fits;

  logic [1:0]                      quadrant;
  logic [mwo_pkg::SINE_IDX_W-1:0]  rom_r;
  logic [mwo_pkg::ROM_ADDR_W-1:0]  rom_idx;
  logic [mwo_pkg::ROM_W-1:0]       rom_val;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_accept  = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = out_last_q;

  always_comb begin
    case (paddr[4:2])
      mwo_pkg::REG_WAVEFORM: prdata = {30'd0, wave_q};
      mwo_pkg::REG_PERIOD:   prdata = {16'd0, period_q};
      mwo_pkg::REG_PULSE_ON: prdata = {16'd0, pulse_on_q};
      mwo_pkg::REG_AMP:      prdata = {16'd0, amp_q};
      mwo_pkg::REG_TOTAL:    prdata = {8'd0, total_q};
      default:               prdata = 32'd0;
    endcase
  end

  // Phase and run bookkeeping for the item being accepted.
  assign n_eff    = (period_q < 16'd2) ? 16'd2 : period_q;
  assign tl_eff   = (total_q == '0) ? TL_W'(1) : total_q;
  assign rc_start = restart_i ? '0 : run_q;
  assign ph_start = restart_i ? 16'd0 : phase_q;
  assign ph_cur   = (ph_start >= n_eff) ? 16'd0 : ph_start;
  assign rc_inc   = LW'(rc_start) + LW'(1);
  assign is_last  = (rc_inc >= LW'(tl_eff)) || (rc_start == CNT_MAX);
  assign ph_inc   = {1'b0, ph_cur} + 17'd1;

  // Shared multiplier: amplitude times phase term, or times the raised cosine.
  assign tri_half = n_eff >> 1;
  assign tri_arg  = (i_q < tri_half) ? i_q : ((tri_half << 1) - i_q);
  assign mul_b    = (state_q == ST_SMUL) ? v_q :
                    ((wave_q == mwo_pkg::WAVE_TRI) ? {2'b00, tri_arg} : {2'b00, i_q});
  assign mul_p    = 34'(amp_q) * 34'(mul_b);
  assign div_num  = (wave_q == mwo_pkg::WAVE_SINE) ? (32'(i_q) << mwo_pkg::PHASE_SHIFT)
                                                   : mul_p[31:0];

  // One restoring divide step per cycle.
  assign trial = {rem_q, quo_q[15]};
  assign fits  = (trial >= {1'b0, den_q});

  assign quadrant = quo_q[mwo_pkg::PHASE_SHIFT-1 -: 2];
  assign rom_r    = quo_q[mwo_pkg::SINE_IDX_W-1:0];
  assign rom_idx  = quadrant[0] ? {1'b0, rom_r}
                                : (mwo_pkg::ROM_ADDR_W'(mwo_pkg::SINE_TABLE_DEPTH)
                                   - {1'b0, rom_r});
  assign rom_val  = mwo_pkg::SINE_ROM[rom_idx];

  always_comb begin
    state_d     = state_q;
    wave_d      = wave_q;
    period_d    = period_q;
    pulse_on_d  = pulse_on_q;
    amp_d       = amp_q;
    total_d     = total_q;
    phase_d     = phase_q;
    run_d       = run_q;
    i_d         = i_q;
    last_d      = last_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    cnt_d       = cnt_q;
    v_d         = v_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_valid_d = out_accept ? 1'b0 : out_valid_q;
    sample_d    = sample_q;
    out_last_d  = out_last_q;

    if (cfg_write) begin
      case (paddr[4:2])
        mwo_pkg::REG_WAVEFORM: wave_d     = pwdata[1:0];
        mwo_pkg::REG_PERIOD:   period_d   = pwdata[15:0];
        mwo_pkg::REG_PULSE_ON: pulse_on_d = pwdata[15:0];
        mwo_pkg::REG_AMP:      amp_d      = pwdata[15:0];
        mwo_pkg::REG_TOTAL:    total_d    = pwdata[TL_W-1:0];
        default:               ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          i_d    = ph_cur;
          last_d = is_last;
          if (is_last) begin
            phase_d = 16'd0;
            run_d   = '0;
          end else begin
            phase_d = (ph_inc >= {1'b0, n_eff}) ? 16'd0 : ph_inc[15:0];
            run_d   = rc_inc[CW-1:0];
          end
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        rem_d = div_num[31:16];
        quo_d = div_num[15:0];
        den_d = (wave_q == mwo_pkg::WAVE_TRI) ? tri_half : n_eff;
        cnt_d = 4'd0;
        case (wave_q)
          mwo_pkg::WAVE_SINE, mwo_pkg::WAVE_SAW, mwo_pkg::WAVE_TRI: state_d = ST_DIV;
          mwo_pkg::WAVE_PULSE: begin
            res_d   = (i_q < pulse_on_q) ? amp_q : 16'd0;
            state_d = ST_FINISH;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        rem_d = fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
        quo_d = {quo_q[14:0], fits};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          if (wave_q == mwo_pkg::WAVE_SINE) begin
            state_d = ST_SROM;
          end else begin
            res_d   = {quo_q[14:0], fits};
            state_d = ST_FINISH;
          end
        end
      end
      ST_SROM: begin
        // Quadrants 0 and 3 subtract the table value from one, 1 and 2 add it.
        if (quadrant[1] == quadrant[0]) begin
          v_d = 18'd65536 - 18'(rom_val);
        end else begin
          v_d = 18'd65536 + 18'(rom_val);
        end
        state_d = ST_SMUL;
      end
      ST_SMUL: begin
        prod_d  = mul_p;
        state_d = ST_SRND;
      end
      ST_SRND: begin
        res_d   = 16'((prod_q + 34'd65536) >> 17);
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          sample_d    = res_q;
          out_last_d  = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wave_q      <= mwo_pkg::WAVE_SINE;
      period_q    <= 16'd100;
      pulse_on_q  <= 16'd50;
      amp_q       <= 16'd32768;
      total_q     <= TL_W'(48000);
      phase_q     <= 16'd0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= 4'd0;
      i_q         <= 16'd0;
      last_q      <= 1'b0;
      rem_q       <= 16'd0;
      quo_q       <= 16'd0;
      den_q       <= 16'd0;
      v_q         <= 18'd0;
      prod_q      <= 34'd0;
      res_q       <= 16'd0;
      sample_q    <= 16'd0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      wave_q      <= wave_d;
      period_q    <= period_d;
      pulse_on_q  <= pulse_on_d;
      amp_q       <= amp_d;
      total_q     <= total_d;
      phase_q     <= phase_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      last_q      <= last_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      den_q       <= den_d;
      v_q         <= v_d;
      prod_q      <= prod_d;
      res_q       <= res_d;
      sample_q    <= sample_d;
      out_last_q  <= out_last_d;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder out of range");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH))
    else $error("result shown without a finished item");

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && !out_valid_q) |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("finished item not moved to the output register");
`endif

endmodule

// ===== bench/multi_waveform_oscillator_unit_tb.sv =====
module multi_waveform_oscillator_unit_tb;

  localparam logic [2:0] REG_UNUSED = 3'd5;

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int unsigned     CYCLE_LIMIT      = 600000;
  localparam int unsigned     RANDOM_TICKS     = 700;

  class tone_tracker;
    typedef struct packed {
      logic [15:0] level;
      logic        last;
    } tone_t;

    bit [1:0]                      shape;
    bit [15:0]                     period;
    bit [15:0]                     on_len;
    bit [15:0]                     amp;
    bit [23:0]                     run_len;
    bit [15:0]                     phase;
    bit [mwo_pkg::COUNT_WIDTH-1:0] count;
    bit [16:0]                     quarter_wave [0:mwo_pkg::SINE_TABLE_DEPTH];
    tone_t                         tones_due [$];
    int unsigned                   mismatches;

    function new();
      longint unsigned d, x, x2, t, s, e;
      d = mwo_pkg::SINE_TABLE_DEPTH;
      for (int k = 0; k <= mwo_pkg::SINE_TABLE_DEPTH; k++) begin
        x  = (QUARTER_TURN_Q30 * 64'(k) + d / 2) / d;
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        // Taylor terms of sin(x): divide by (2n)(2n+1) at each step.
        for (int n = 1; n <= 7; n++) begin
          t = ((t * x2) >> 30) / 64'(4 * n * n + 2 * n);
          if (n % 2 == 1) begin
            s = (s >= t) ? s - t : 64'd0;
          end else begin
            s = s + t;
          end
        end
        e = (s + 64'd8192) >> 14;
        quarter_wave[k] = (e > 64'd65536) ? 17'd65536 : 17'(e);
      end
      shape      = mwo_pkg::WAVE_SINE;
      period     = 16'd100;
      on_len     = 16'd50;
      amp        = 16'd32768;
      run_len    = 24'd48000;
      phase      = '0;
      count      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        mwo_pkg::REG_WAVEFORM: shape   = data[1:0];
        mwo_pkg::REG_PERIOD:   period  = data[15:0];
        mwo_pkg::REG_PULSE_ON: on_len  = data[15:0];
        mwo_pkg::REG_AMP:      amp     = data[15:0];
        mwo_pkg::REG_TOTAL:    run_len = data[23:0];
        default: ;
      endcase
    endfunction

    function void take_tick(bit restart);
      longint unsigned n, tl, a, i, m, lvl, p, r, v;
      bit [1:0] q;
      bit       fin;
      tone_t    tone;
      n  = (period < 16'd2) ? 64'd2 : 64'(period);
      tl = (run_len == 24'd0) ? 64'd1 : 64'(run_len);
      a  = amp;
      if (restart) begin
        phase = '0;
        count = '0;
      end
      if (64'(phase) >= n) begin
        phase = '0;
      end
      i = phase;
      case (shape)
        mwo_pkg::WAVE_SINE: begin
          p = (i * 4 * mwo_pkg::SINE_TABLE_DEPTH) / n;
          q = 2'(p / mwo_pkg::SINE_TABLE_DEPTH);
          r = p % mwo_pkg::SINE_TABLE_DEPTH;
          case (q)
            2'd0: v = 64'd65536 - quarter_wave[mwo_pkg::SINE_TABLE_DEPTH - r];
            2'd1: v = 64'd65536 + quarter_wave[r];
            2'd2: v = 64'd65536 + quarter_wave[mwo_pkg::SINE_TABLE_DEPTH - r];
            default: v = 64'd65536 - quarter_wave[r];
          endcase
          lvl = (a * v + 64'd65536) >> 17;
        end
        mwo_pkg::WAVE_SAW: lvl = (a * i) / n;
        mwo_pkg::WAVE_TRI: begin
          m   = n / 2;
          lvl = (i < m) ? (a * i) / m : (a * (2 * m - i)) / m;
        end
        default: lvl = (i < 64'(on_len)) ? a : 64'd0;
      endcase
      fin = (64'(count) + 64'd1 >= tl) || (count == '1);
      if (fin) begin
        phase = '0;
        count = '0;
      end else begin
        phase = (i + 1 >= n) ? 16'd0 : 16'(i + 1);
        count = count + 1'b1;
      end
      tone.level = 16'(lvl);
      tone.last  = fin;
      tones_due.push_back(tone);
    endfunction

    function void match_output(logic [15:0] level, logic last);
      tone_t want;
      if (tones_due.size() == 0) begin
        $error("output transfer with nothing pending: sample %0d last %0d", level, last);
        mismatches++;
        return;
      end
      want = tones_due.pop_front();
      if (level !== want.level) begin
        $error("sample: expected %0d, got %0d", want.level, level);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        restart_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] sample_o;
  logic        last_o;
  logic        calm        = 1'b0;
  int unsigned cycles      = 0;

  tone_tracker tones = new();

  multi_waveform_oscillator_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Output side: check the transfer of this edge, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tones.match_output(sample_o, last_o);
    end
    out_stall_i <= !calm && ($urandom_range(99) < 35);
  end

  task automatic put_reg(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tones.set_reg(idx, data);
  endtask

  task automatic end_bus();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper data bits beyond each register are filled with noise; they must be dropped.
  task automatic program_all(logic [1:0] wave, logic [15:0] per, logic [15:0] on,
                             logic [15:0] level, logic [23:0] run);
    put_reg(mwo_pkg::REG_WAVEFORM, {30'($urandom), wave});
    put_reg(mwo_pkg::REG_PERIOD, {16'($urandom), per});
    put_reg(mwo_pkg::REG_PULSE_ON, {16'($urandom), on});
    put_reg(mwo_pkg::REG_AMP, {16'($urandom), level});
    put_reg(mwo_pkg::REG_TOTAL, {8'($urandom), run});
    end_bus();
  endtask

  task automatic random_setup();
    int unsigned pick;
    logic [15:0] per;
    logic [15:0] on;
    logic [15:0] level;
    logic [23:0] run;
    if ($urandom_range(3) != 0) begin
      put_reg(mwo_pkg::REG_WAVEFORM, $urandom);
    end
    if ($urandom_range(3) != 0) begin
      pick = $urandom_range(99);
      if (pick < 60) per = 16'($urandom_range(2, 40));
      else if (pick < 75) per = 16'($urandom_range(41, 1000));
      else if (pick < 85) per = 16'($urandom_range(1));
      else if (pick < 95) per = 16'($urandom);
      else per = 16'hFFFF;
      put_reg(mwo_pkg::REG_PERIOD, {16'($urandom), per});
    end
    if ($urandom_range(3) != 0) begin
      if ($urandom_range(9) < 7) on = 16'($urandom_range(0, int'(tones.period) + 3));
      else on = 16'($urandom);
      put_reg(mwo_pkg::REG_PULSE_ON, {16'($urandom), on});
    end
    if ($urandom_range(3) != 0) begin
      pick = $urandom_range(99);
      if (pick < 10) level = 16'd0;
      else if (pick < 20) level = 16'hFFFF;
      else level = 16'($urandom);
      put_reg(mwo_pkg::REG_AMP, {16'($urandom), level});
    end
    if ($urandom_range(3) != 0) begin
      pick = $urandom_range(99);
      if (pick < 45) run = 24'($urandom_range(1, 60));
      else if (pick < 75) run = 24'($urandom_range(61, 2000));
      else if (pick < 85) run = 24'd0;
      else run = 24'($urandom);
      put_reg(mwo_pkg::REG_TOTAL, {8'($urandom), run});
    end
    if ($urandom_range(9) == 0) begin
      put_reg(3'(REG_UNUSED + $urandom_range(2)), $urandom);
    end
    end_bus();
  endtask

  task automatic send_tick(logic rs);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 35) begin
      gap = ($urandom_range(2) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tones.take_tick(rs);
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tones.tones_due.size() != 0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned span;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults straight after reset.
    send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();

    // Period below two and a zero run length: every sample closes a run.
    put_reg(REG_UNUSED, $urandom);
    program_all(mwo_pkg::WAVE_SINE, 16'd1, 16'd0, 16'hFFFF, 24'd0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_quiet();

    program_all(mwo_pkg::WAVE_SAW, 16'hFFFF, 16'd0, 16'hFFFF, 24'd3);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_quiet();

    program_all(mwo_pkg::WAVE_TRI, 16'd3, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_quiet();

    // An on-length past the period keeps the pulse high throughout.
    program_all(mwo_pkg::WAVE_PULSE, 16'd4, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();
    put_reg(mwo_pkg::REG_PULSE_ON, 32'd0);
    end_bus();
    send_tick(1'b0);
    wait_quiet();

    // Shrink period and run length below the current phase and count.
    program_all(mwo_pkg::WAVE_TRI, 16'd20, 16'd0, 16'd40000, 24'd100);
    send_tick(1'b1);
    repeat (5) send_tick(1'b0);
    wait_quiet();
    put_reg(mwo_pkg::REG_PERIOD, 32'd5);
    put_reg(mwo_pkg::REG_TOTAL, 32'd3);
    end_bus();
    send_tick(1'b0);
    send_tick(1'b0);
    wait_quiet();

    sent = 0;
    while (sent < RANDOM_TICKS) begin
      random_setup();
      span = $urandom_range(5, 40);
      for (int j = 0; j < span; j++) begin
        calm <= (sent >= 250 && sent < 380);
        send_tick($urandom_range(99) < 6);
        sent++;
        if (sent == 500) begin
          wait_quiet();
        end
      end
      wait_quiet();
    end

    repeat (40) @(posedge clk_i);
    if (tones.mismatches == 0 && tones.tones_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mwo_pkg.sv
design/multi_waveform_oscillator_unit.sv
bench/multi_waveform_oscillator_unit_tb.sv
